// ----- rtl/cilc_pkg.sv -----
package cilc_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_LINE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_ACK    = 2'd2,
    OP_UNUSED = 2'd3
  } cilc_op_e;

  // line number of the clock source and the levels it may be routed to
  localparam logic [3:0] CLOCK_SOURCE_LEVEL = 4'd8;
  localparam logic [2:0] CLOCK_LEVEL_A      = 3'd5;
  localparam logic [2:0] CLOCK_LEVEL_B      = 3'd7;
  localparam logic [2:0] LEVEL_NONE         = 3'd0;

  // soft interrupt levels
  localparam logic [2:0] SOFT_LEVEL_1 = 3'd1;
  localparam logic [2:0] SOFT_LEVEL_2 = 3'd2;
  localparam logic [2:0] SOFT_LEVEL_3 = 3'd3;

  // interrupt register bit positions
  localparam int unsigned IREG_ENABLE_BIT = 0;
  localparam int unsigned IREG_SOFT1_BIT  = 1;
  localparam int unsigned IREG_SOFT2_BIT  = 2;
  localparam int unsigned IREG_SOFT3_BIT  = 3;
  localparam int unsigned IREG_CLOCK5_BIT = 5;
  localparam int unsigned IREG_CLOCK7_BIT = 7;

  localparam int unsigned NUM_LINES = 7;

  typedef struct packed {
    cilc_op_e    op;
    logic [3:0]  level;
    logic        asserted;
    logic [7:0]  intreg_value;
  } cilc_in_t;

  typedef struct packed {
    logic [2:0] cpu_level;
    logic       level_changed;
    logic       soft_claimed;
    logic       clock_alias;
  } cilc_out_t;

endpackage

// ----- rtl/cpu_interrupt_level_controller_unit.sv -----
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid_i/in_stall_o   | cilc_in_t: op, level, asserted, value
// out     | output    | out_valid_o/out_stall_i | cilc_out_t: level, changed, soft, alias
//
// one transaction per cycle sustained while the output is not stalled; an accepted
// transaction passes through the input register, then is evaluated into the result
// register, from which it is offered on the out channel
// reset clears the pending bits, interrupt register, clock routing and level
// a stall on the output holds the result register and, once the input
// register is full too, raises in_stall_o
module cpu_interrupt_level_controller_unit import cilc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cilc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cilc_out_t out_data_o
);

  logic      s1_valid_q, s1_valid_d;
  cilc_in_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  cilc_out_t out_data_q;
  cilc_out_t result;
  logic      out_free;
  logic      s1_adv;
  logic      in_acc;

  // handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // evaluation and state
  cilc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_adv),
    .item_i   (s1_item_q),
    .result_o (result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) s1_item_q <= in_data_i;
    if (s1_adv) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.soft_claimed && out_data_o.clock_alias))
    else $error("soft claim and clock alias both set");

  a_ack_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.soft_claimed || out_data_o.clock_alias)
      |-> !out_data_o.level_changed)
    else $error("acknowledge reported a level change");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("evaluated transaction lost");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free stages");

endmodule

// ----- rtl/cilc_core.sv -----
module cilc_core import cilc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cilc_in_t  item_i,
  output cilc_out_t result_o
);

  logic [NUM_LINES-1:0] pending_q, pending_d;
  logic [7:0]           ireg_q, ireg_d;
  logic [2:0]           route_q, route_d;
  logic [2:0]           driven_q, driven_d;

  logic [3:0]           line;
  logic                 line_ok;
  logic                 reeval;
  logic [2:0]           top_pend;
  logic [2:0]           new_level;
  logic                 soft_hit;

  // resolve the line of a signal event, including clock routing
  always_comb begin
    route_d = route_q;
    line    = item_i.level;
    if (item_i.op == OP_LINE && item_i.level == CLOCK_SOURCE_LEVEL) begin
      if (item_i.asserted) begin
        if (ireg_q[IREG_CLOCK5_BIT]) begin
          route_d = CLOCK_LEVEL_A;
        end else if (ireg_q[IREG_CLOCK7_BIT]) begin
          route_d = CLOCK_LEVEL_B;
        end else begin
          route_d = LEVEL_NONE;
        end
        line = {1'b0, route_d};
      end else begin
        line = {1'b0, route_q};
      end
    end
    line_ok = (line != 4'd0) && (line <= 4'(NUM_LINES));
  end

  // next pending bits and interrupt register
  always_comb begin
    pending_d = pending_q;
    ireg_d    = ireg_q;
    reeval    = 1'b0;
    unique case (item_i.op)
      OP_LINE: begin
        if (line_ok) begin
          pending_d[line[2:0] - 3'd1] = item_i.asserted;
          reeval = 1'b1;
        end
      end
      OP_WRITE: begin
        ireg_d = item_i.intreg_value;
        reeval = 1'b1;
      end
      default: ;
    endcase
  end

  // highest pending level, raised by soft levels, gated by enable
  always_comb begin
    top_pend = LEVEL_NONE;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (pending_d[i]) top_pend = 3'(i + 1);
    end
    new_level = top_pend;
    if (ireg_d[IREG_SOFT3_BIT]) begin
      if (new_level < SOFT_LEVEL_3) new_level = SOFT_LEVEL_3;
    end else if (ireg_d[IREG_SOFT2_BIT]) begin
      if (new_level < SOFT_LEVEL_2) new_level = SOFT_LEVEL_2;
    end else if (ireg_d[IREG_SOFT1_BIT]) begin
      if (new_level < SOFT_LEVEL_1) new_level = SOFT_LEVEL_1;
    end
    if (!ireg_d[IREG_ENABLE_BIT]) new_level = LEVEL_NONE;
    driven_d = reeval ? new_level : driven_q;
  end

  // acknowledge decode
  always_comb begin
    soft_hit = (item_i.level == {1'b0, SOFT_LEVEL_3} && ireg_q[IREG_SOFT3_BIT]) ||
               (item_i.level == {1'b0, SOFT_LEVEL_2} && ireg_q[IREG_SOFT2_BIT]) ||
               (item_i.level == {1'b0, SOFT_LEVEL_1} && ireg_q[IREG_SOFT1_BIT]);
    result_o.cpu_level     = driven_d;
    result_o.level_changed = reeval && (new_level != driven_q);
    result_o.soft_claimed  = (item_i.op == OP_ACK) && soft_hit;
    result_o.clock_alias   = (item_i.op == OP_ACK) && !soft_hit &&
                             (route_q != LEVEL_NONE) &&
                             (item_i.level == {1'b0, route_q});
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      ireg_q    <= '0;
      route_q   <= LEVEL_NONE;
      driven_q  <= LEVEL_NONE;
    end else if (en_i) begin
      pending_q <= pending_d;
      ireg_q    <= ireg_d;
      route_q   <= route_d;
      driven_q  <= driven_d;
    end
  end

endmodule

// ----- tb/cpu_interrupt_level_controller_unit_test.sv -----
module cpu_interrupt_level_controller_unit_test;
  import cilc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED   = 50;

  // tracks the controller state and the results still owed by the block
  class level_scoreboard;
    logic [6:0] pend_lines;
    logic [7:0] int_reg;
    logic [2:0] clk_route;
    logic [2:0] drv_level;
    cilc_out_t  due_results[$];
    int         errors;

    function new();
      pend_lines = '0;
      int_reg    = '0;
      clk_route  = LEVEL_NONE;
      drv_level  = LEVEL_NONE;
      errors     = 0;
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // highest pending line, lifted to the highest soft level, gated by enable
    function logic refresh_level();
      logic [2:0] lvl;
      logic       changed;
      int         i;
      lvl = LEVEL_NONE;
      if (int_reg[IREG_ENABLE_BIT]) begin
        for (i = NUM_LINES; i >= 1; i--)
          if (pend_lines[i-1] && lvl == LEVEL_NONE) lvl = 3'(i);
        if (int_reg[IREG_SOFT3_BIT]) begin
          if (lvl < SOFT_LEVEL_3) lvl = SOFT_LEVEL_3;
        end else if (int_reg[IREG_SOFT2_BIT]) begin
          if (lvl < SOFT_LEVEL_2) lvl = SOFT_LEVEL_2;
        end else if (int_reg[IREG_SOFT1_BIT]) begin
          if (lvl < SOFT_LEVEL_1) lvl = SOFT_LEVEL_1;
        end
      end
      changed   = (lvl != drv_level);
      drv_level = lvl;
      return changed;
    endfunction

    function cilc_out_t predict_result(cilc_in_t t);
      cilc_out_t  r;
      logic [3:0] line;
      r = '0;
      case (t.op)
        OP_LINE: begin
          line = t.level;
          // the clock source maps onto a routed level
          if (t.level == CLOCK_SOURCE_LEVEL) begin
            if (t.asserted) begin
              if (int_reg[IREG_CLOCK5_BIT])      line = {1'b0, CLOCK_LEVEL_A};
              else if (int_reg[IREG_CLOCK7_BIT]) line = {1'b0, CLOCK_LEVEL_B};
              else                               line = {1'b0, LEVEL_NONE};
              clk_route = line[2:0];
            end else begin
              line = {1'b0, clk_route};
            end
          end
          if (line >= 1 && line <= NUM_LINES) begin
            pend_lines[line-1] = t.asserted;
            r.level_changed    = refresh_level();
          end
        end
        OP_WRITE: begin
          int_reg         = t.intreg_value;
          r.level_changed = refresh_level();
        end
        OP_ACK: begin
          if ((t.level == SOFT_LEVEL_3 && int_reg[IREG_SOFT3_BIT]) ||
              (t.level == SOFT_LEVEL_2 && int_reg[IREG_SOFT2_BIT]) ||
              (t.level == SOFT_LEVEL_1 && int_reg[IREG_SOFT1_BIT]))
            r.soft_claimed = 1'b1;
          else if (clk_route != LEVEL_NONE && t.level == {1'b0, clk_route})
            r.clock_alias = 1'b1;
        end
        default: ;
      endcase
      r.cpu_level = drv_level;
      return r;
    endfunction

    function void note_request(cilc_in_t t);
      due_results.push_back(predict_result(t));
    endfunction

    task check_result(cilc_out_t got);
      cilc_out_t want;
      if (due_results.size() == 0) begin
        report("result with nothing outstanding", got, 0);
      end else begin
        want = due_results.pop_front();
        if (got.cpu_level != want.cpu_level)
          report("cpu_level", got.cpu_level, want.cpu_level);
        if (got.level_changed != want.level_changed)
          report("level_changed", got.level_changed, want.level_changed);
        if (got.soft_claimed != want.soft_claimed)
          report("soft_claimed", got.soft_claimed, want.soft_claimed);
        if (got.clock_alias != want.clock_alias)
          report("clock_alias", got.clock_alias, want.clock_alias);
      end
    endtask

    function int pending_count();
      return due_results.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  cilc_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  cilc_out_t out_data_o;

  level_scoreboard sb;
  logic            no_idle;
  logic            hold_pending;
  int              idle_cycles;

  cpu_interrupt_level_controller_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // cycles either side waits before its next transaction
  function int draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 16);
    return $urandom_range(0, 1);
  endfunction

  function cilc_in_t make_item(cilc_op_e op, logic [3:0] lvl, logic asserted,
                               logic [7:0] value);
    cilc_in_t t;
    t.op           = op;
    t.level        = lvl;
    t.asserted     = asserted;
    t.intreg_value = value;
    return t;
  endfunction

  // mostly line events and writes that keep the block enabled, some noise
  function cilc_in_t random_event();
    cilc_in_t t;
    int       pick;
    t.op           = OP_LINE;
    t.level        = 4'($urandom_range(1, 8));
    t.asserted     = 1'($urandom_range(0, 1));
    t.intreg_value = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick >= 55 && pick < 70) begin
      t.op = OP_WRITE;
      if ($urandom_range(0, 99) < 85) t.intreg_value[IREG_ENABLE_BIT] = 1'b1;
    end else if (pick >= 70 && pick < 88) begin
      t.op = OP_ACK;
      t.level = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 7));
    end else if (pick >= 88 && pick < 95) begin
      // line numbers outside the valid range
      t.level = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    end else if (pick >= 95) begin
      t.op    = OP_UNUSED;
      t.level = 4'($urandom_range(0, 15));
    end
    return t;
  endfunction

  // offer one transaction and wait for it to be taken
  task send_item(cilc_in_t t);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering until every owed result has come back
  task wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  task run_directed();
    // line pending while disabled, then enable
    send_item(make_item(OP_LINE, 4'd3, 1'b1, 8'h00));
    send_item(make_item(OP_WRITE, 4'd0, 1'b0, 8'h01));
    send_item(make_item(OP_LINE, 4'd7, 1'b1, 8'hFF));
    send_item(make_item(OP_LINE, 4'd1, 1'b1, 8'h00));
    send_item(make_item(OP_LINE, 4'd7, 1'b0, 8'h00));
    // clock events with no routing are ignored
    send_item(make_item(OP_LINE, CLOCK_SOURCE_LEVEL, 1'b1, 8'h00));
    send_item(make_item(OP_LINE, CLOCK_SOURCE_LEVEL, 1'b0, 8'h00));
    // routing to level 5 wins over level 7
    send_item(make_item(OP_WRITE, 4'd0, 1'b0, 8'hA1));
    send_item(make_item(OP_LINE, CLOCK_SOURCE_LEVEL, 1'b1, 8'h00));
    send_item(make_item(OP_ACK, 4'd5, 1'b0, 8'h00));
    // negation reuses the remembered route even after the register moves
    send_item(make_item(OP_WRITE, 4'd0, 1'b0, 8'h81));
    send_item(make_item(OP_LINE, CLOCK_SOURCE_LEVEL, 1'b0, 8'h00));
    send_item(make_item(OP_LINE, CLOCK_SOURCE_LEVEL, 1'b1, 8'h00));
    send_item(make_item(OP_ACK, 4'd7, 1'b0, 8'h00));
    // soft interrupts claim acknowledges
    send_item(make_item(OP_WRITE, 4'd0, 1'b0, 8'h8F));
    send_item(make_item(OP_ACK, 4'd3, 1'b0, 8'h00));
    send_item(make_item(OP_ACK, 4'd2, 1'b0, 8'h00));
    send_item(make_item(OP_ACK, 4'd1, 1'b0, 8'h00));
    // out of range lines and the unused operation
    send_item(make_item(OP_LINE, 4'd0, 1'b1, 8'h00));
    send_item(make_item(OP_LINE, 4'd9, 1'b1, 8'h00));
    send_item(make_item(OP_LINE, 4'd15, 1'b0, 8'h00));
    send_item(make_item(OP_UNUSED, 4'd15, 1'b1, 8'hFF));
    // disable forces zero, an ack above seven never aliases
    send_item(make_item(OP_WRITE, 4'd0, 1'b0, 8'h0E));
    send_item(make_item(OP_ACK, 4'd15, 1'b1, 8'hFF));
    send_item(make_item(OP_WRITE, 4'd0, 1'b0, 8'hFF));
  endtask

  // sender
  initial begin
    int i;
    sb           = new();
    no_idle      = 1'b0;
    hold_pending = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == 600) hold_pending = 1'b1;
      if (i == 1200) wait_drained();
      send_item(random_event());
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // receiver
  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      // one long hold so the block backs up onto its input
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      n = draw_wait();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // monitor both channels and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule
